>>> hw/rtl/assert_macros.svh
// Assertion macros for self-checking RTL; the allocator top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fba_pkg.sv
// Shared types, codes and constants of the first-fit block allocator.
package fba_pkg;

  localparam int SIZE_W = 17;
  localparam int ADDR_W = 16;
  localparam int STAT_W = 2;
  localparam int OFF_W  = 18;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int LIM_CAP      = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

  localparam logic [SIZE_W-1:0] LIM_CAP_V   = SIZE_W'(LIM_CAP);
  localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(65536);
  localparam logic [OFF_W-1:0]  HDR_OFF     = OFF_W'(HEADER_BYTES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } blk_ent_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_IGNORE,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_UNKNOWN,
    OP_CLAIM,
    OP_APPEND,
    OP_MERGE,
    OP_SHIFT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic ignore;
    logic is_free;
    logic empty;
    logic hit;
    logic last;
    logic merge_none;
    logic shift_done;
  } dp_stat_t;

endpackage

>>> hw/rtl/fba_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
interface fba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [fba_pkg::SIZE_W-1:0]    size;
  logic [fba_pkg::ADDR_W-1:0]    address;

  modport source (output valid, output cmd, output size, output address, input ready);
  modport sink   (input valid, input cmd, input size, input address, output ready);
endinterface

interface fba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::STAT_W-1:0]    status;
  logic [fba_pkg::ADDR_W-1:0]    address_out;

  modport source (output valid, output status, output address_out, input ready);
  modport sink   (input valid, input status, input address_out, output ready);
endinterface

>>> hw/rtl/fba_datapath.sv
// Allocator datapath: block table memory, walk counters, offset adders, result registers.
module fba_datapath #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fba_pkg::dp_cmd_t            cmd,
  output fba_pkg::dp_stat_t           stat,
  input  logic                        cfg_we,
  input  logic [fba_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic                        in_cmd,
  input  logic [fba_pkg::SIZE_W-1:0]  in_size,
  input  logic [fba_pkg::ADDR_W-1:0]  in_address,
  output logic [fba_pkg::STAT_W-1:0]  out_status,
  output logic [fba_pkg::ADDR_W-1:0]  out_address_out
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // block table: payload size and free mark per entry, address ordered
  fba_pkg::blk_ent_t mem [MAX_BLOCKS];
  fba_pkg::blk_ent_t rd_data_r;
  fba_pkg::blk_ent_t prev_r;
  fba_pkg::blk_ent_t hit_r;

  logic                       item_cmd_r;
  logic [fba_pkg::SIZE_W-1:0] item_size_r;
  logic [fba_pkg::ADDR_W-1:0] item_addr_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] ev_idx_r;
  logic [CW-1:0] src_r;
  logic [CW-1:0] dst_r;
  logic [CW-1:0] end_r;
  logic          pend_r;
  logic          prev_ok_r;

  logic [fba_pkg::OFF_W-1:0]  cur_off_r;
  logic [fba_pkg::OFF_W-1:0]  prev_off_r;
  logic [fba_pkg::SIZE_W-1:0] heap_top_r;
  logic [fba_pkg::SIZE_W-1:0] heap_limit_r;

  logic [fba_pkg::STAT_W-1:0] res_status_r;
  logic [fba_pkg::ADDR_W-1:0] res_addr_r;
  logic [fba_pkg::STAT_W-1:0] out_status_r;
  logic [fba_pkg::ADDR_W-1:0] out_addr_r;

  logic                       hit;
  logic [CW-1:0]              ev_inc;
  logic [fba_pkg::OFF_W-1:0]  next_off;
  logic [fba_pkg::OFF_W-1:0]  claim_addr;
  logic                       pf;
  logic                       nf;
  logic [fba_pkg::OFF_W-1:0]  sum_p;
  logic [fba_pkg::OFF_W-1:0]  sum1;
  logic [fba_pkg::OFF_W-1:0]  sum2;
  logic [CW-1:0]              merge_idx;
  logic [CW-1:0]              drop;
  logic [fba_pkg::OFF_W-1:0]  merge_addr;
  logic [fba_pkg::SIZE_W-1:0] lim;
  logic [fba_pkg::SIZE_W-1:0] room;
  logic [fba_pkg::OFF_W-1:0]  need;
  logic [fba_pkg::OFF_W-1:0]  top_addr;
  logic [fba_pkg::OFF_W-1:0]  top_nxt;
  logic                       fits;
  logic                       shift_rd_ok;

  logic [IW-1:0]              rd_addr;
  logic                       wr_en;
  logic [IW-1:0]              wr_idx;
  fba_pkg::blk_ent_t          wr_data;

  // scan compare
  assign hit = (item_cmd_r == fba_pkg::CMD_FREE) ?
               ((cur_off_r + fba_pkg::HDR_OFF) == {2'b00, item_addr_r}) :
               (rd_data_r.free && (rd_data_r.size >= item_size_r));
  assign ev_inc     = ev_idx_r + CW'(1);
  assign next_off   = cur_off_r + fba_pkg::HDR_OFF + {1'b0, rd_data_r.size};
  assign claim_addr = cur_off_r + fba_pkg::HDR_OFF;

  // coalescing; rd_data_r holds the entry after the hit during the merge cycle
  assign pf        = prev_ok_r && prev_r.free;
  assign nf        = (ev_inc < count_r) && rd_data_r.free;
  assign sum_p     = {1'b0, prev_r.size} + fba_pkg::HDR_OFF + {1'b0, hit_r.size};
  assign sum1      = pf ? sum_p : {1'b0, hit_r.size};
  assign sum2      = nf ? (sum1 + fba_pkg::HDR_OFF + {1'b0, rd_data_r.size}) : sum1;
  assign merge_idx = pf ? (ev_idx_r - CW'(1)) : ev_idx_r;
  assign drop      = CW'(pf) + CW'(nf);
  assign merge_addr = (pf ? prev_off_r : cur_off_r) + fba_pkg::HDR_OFF;

  // growth at heap top
  assign lim      = (heap_limit_r > fba_pkg::LIM_CAP_V) ? fba_pkg::LIM_CAP_V : heap_limit_r;
  assign room     = lim - heap_top_r;
  assign need     = fba_pkg::HDR_OFF + {1'b0, item_size_r};
  assign top_addr = {1'b0, heap_top_r} + fba_pkg::HDR_OFF;
  assign top_nxt  = {1'b0, heap_top_r} + need;
  assign fits     = (count_r < CW'(MAX_BLOCKS)) && (heap_top_r <= lim) &&
                    (need <= {1'b0, room});

  assign shift_rd_ok = src_r < end_r;

  always_comb begin
    stat.ignore     = (item_cmd_r == fba_pkg::CMD_FREE) ? (item_addr_r == '0) :
                                                          (item_size_r == '0);
    stat.is_free    = item_cmd_r == fba_pkg::CMD_FREE;
    stat.empty      = count_r == '0;
    stat.hit        = hit;
    stat.last       = ev_inc == count_r;
    stat.merge_none = !pf && !nf;
    stat.shift_done = !pend_r && !shift_rd_ok;
  end

  always_comb begin
    rd_addr = rd_idx_r[IW-1:0];
    wr_en   = 1'b0;
    wr_idx  = ev_idx_r[IW-1:0];
    wr_data = hit_r;
    unique case (cmd.op)
      fba_pkg::OP_SCAN_INIT: rd_addr = '0;
      fba_pkg::OP_CLAIM: begin
        wr_en   = 1'b1;
        wr_data = '{free: 1'b0, size: hit_r.size};
      end
      fba_pkg::OP_APPEND: begin
        wr_en   = fits;
        wr_idx  = count_r[IW-1:0];
        wr_data = '{free: 1'b0, size: item_size_r};
      end
      fba_pkg::OP_MERGE: begin
        wr_en   = 1'b1;
        wr_idx  = merge_idx[IW-1:0];
        wr_data = '{free: 1'b1, size: sum2[fba_pkg::SIZE_W-1:0]};
      end
      fba_pkg::OP_SHIFT: begin
        rd_addr = src_r[IW-1:0];
        wr_en   = pend_r;
        wr_idx  = dst_r[IW-1:0];
        wr_data = rd_data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      heap_top_r   <= '0;
      heap_limit_r <= fba_pkg::LIMIT_RESET;
      pend_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit_r <= cfg_wdata;
      end
      unique case (cmd.op)
        fba_pkg::OP_APPEND: begin
          if (fits) begin
            count_r    <= count_r + CW'(1);
            heap_top_r <= top_nxt[fba_pkg::SIZE_W-1:0];
          end
        end
        fba_pkg::OP_MERGE: begin
          count_r <= count_r - drop;
          pend_r  <= 1'b0;
        end
        fba_pkg::OP_SHIFT: pend_r <= shift_rd_ok;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      fba_pkg::OP_LOAD: begin
        item_cmd_r  <= in_cmd;
        item_size_r <= in_size;
        item_addr_r <= in_address;
      end
      fba_pkg::OP_IGNORE: begin
        res_status_r <= fba_pkg::ST_IGNORED;
        res_addr_r   <= '0;
      end
      fba_pkg::OP_SCAN_INIT: begin
        rd_idx_r  <= CW'(1);
        ev_idx_r  <= '0;
        cur_off_r <= '0;
        prev_ok_r <= 1'b0;
      end
      fba_pkg::OP_SCAN: begin
        if (hit) begin
          hit_r <= rd_data_r;
        end else begin
          prev_r     <= rd_data_r;
          prev_off_r <= cur_off_r;
          prev_ok_r  <= 1'b1;
          cur_off_r  <= next_off;
          ev_idx_r   <= ev_inc;
          rd_idx_r   <= rd_idx_r + CW'(1);
        end
      end
      fba_pkg::OP_UNKNOWN: begin
        res_status_r <= fba_pkg::ST_UNKNOWN;
        res_addr_r   <= '0;
      end
      fba_pkg::OP_CLAIM: begin
        res_status_r <= fba_pkg::ST_DONE;
        res_addr_r   <= claim_addr[fba_pkg::ADDR_W-1:0];
      end
      fba_pkg::OP_APPEND: begin
        if (fits) begin
          res_status_r <= fba_pkg::ST_DONE;
          res_addr_r   <= top_addr[fba_pkg::ADDR_W-1:0];
        end else begin
          res_status_r <= fba_pkg::ST_NO_SPACE;
          res_addr_r   <= '0;
        end
      end
      fba_pkg::OP_MERGE: begin
        res_status_r <= fba_pkg::ST_DONE;
        res_addr_r   <= merge_addr[fba_pkg::ADDR_W-1:0];
        src_r        <= merge_idx + CW'(1) + drop;
        dst_r        <= merge_idx + CW'(1);
        end_r        <= count_r;
      end
      fba_pkg::OP_SHIFT: begin
        if (pend_r) begin
          dst_r <= dst_r + CW'(1);
        end
        if (shift_rd_ok) begin
          src_r <= src_r + CW'(1);
        end
      end
      fba_pkg::OP_OUT: begin
        out_status_r <= res_status_r;
        out_addr_r   <= res_addr_r;
      end
      default: ;
    endcase
  end

  assign out_status      = out_status_r;
  assign out_address_out = out_addr_r;

endmodule

>>> hw/rtl/fba_ctrl.sv
// Allocator sequencer: request intake, table walk, merge/compaction steps, response handoff.
module fba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fba_pkg::dp_cmd_t   cmd,
  input  fba_pkg::dp_stat_t  stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_CLAIM,
    S_APPEND,
    S_UNKNOWN,
    S_MERGE,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = fba_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = fba_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.ignore) begin
          cmd.op    = fba_pkg::OP_IGNORE;
          state_nxt = S_RESP;
        end else if (stat.empty) begin
          state_nxt = stat.is_free ? S_UNKNOWN : S_APPEND;
        end else begin
          cmd.op    = fba_pkg::OP_SCAN_INIT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = fba_pkg::OP_SCAN;
        if (stat.hit) begin
          state_nxt = stat.is_free ? S_MERGE : S_CLAIM;
        end else if (stat.last) begin
          state_nxt = stat.is_free ? S_UNKNOWN : S_APPEND;
        end
      end
      S_CLAIM: begin
        cmd.op    = fba_pkg::OP_CLAIM;
        state_nxt = S_RESP;
      end
      S_APPEND: begin
        cmd.op    = fba_pkg::OP_APPEND;
        state_nxt = S_RESP;
      end
      S_UNKNOWN: begin
        cmd.op    = fba_pkg::OP_UNKNOWN;
        state_nxt = S_RESP;
      end
      S_MERGE: begin
        cmd.op    = fba_pkg::OP_MERGE;
        state_nxt = stat.merge_none ? S_RESP : S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = S_RESP;
        end else begin
          cmd.op = fba_pkg::OP_SHIFT;
        end
      end
      S_RESP: begin
        // hand over only once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op    = fba_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == fba_pkg::OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator with coalescing.
//
// Requests arrive on in_ch (cmd 0 = allocate size bytes, cmd 1 = free the
// block at payload offset address); one response per request leaves on out_ch
// as status and address_out. cfg_we/cfg_wdata set the usable arena size.
// Requests are handled one at a time; in_ch.ready is high only while idle.
// An ignored request (zero size or null address) goes straight to the response;
// an allocate walks the table first-fit, and a free walks to the matched entry
// and, when blocks merge, compacts the table.
// All walks go through the single read port of the block table memory, one
// entry per cycle. A finished response sits in an output register; the next
// request is taken while it waits, and the block holds before handing over a
// further response until out_ch.ready takes the pending beat.
// Reset (rst_n low, synchronous) empties the heap and sets the limit to
// 65536 bytes; no table clearing is needed.
`include "assert_macros.svh"

module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fba_req_if.sink                    in_ch,
  fba_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [fba_pkg::SIZE_W-1:0] cfg_wdata
);

  fba_pkg::dp_cmd_t  dp_cmd;
  fba_pkg::dp_stat_t dp_stat;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  fba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_ch.cmd),
    .in_size         (in_ch.size),
    .in_address      (in_ch.address),
    .out_status      (out_ch.status),
    .out_address_out (out_ch.address_out)
  );

  `FBA_ASSERT_NEXT(a_one_request_in_flight, in_ch.valid && in_ch.ready,
                   !in_ch.ready, "request accepted while busy")
  `FBA_ASSERT_SAME(a_no_response_overwrite, dp_cmd.op == fba_pkg::OP_OUT,
                   !out_ch.valid || out_ch.ready, "pending response overwritten")
  `FBA_ASSERT_SAME(a_failed_addr_zero, out_ch.valid && (out_ch.status != fba_pkg::ST_DONE),
                   out_ch.address_out == '0, "nonzero address on failed request")

endmodule
